>>> hdl/srtf_preemptive_scheduler_assert.svh
// ----------------------------------------------------------------------------
// srtf scheduler assertion macros
// clocked implication checks, reset masked
// ----------------------------------------------------------------------------
`ifndef SRTF_PREEMPTIVE_SCHEDULER_ASSERT_SVH
`define SRTF_PREEMPTIVE_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define SRTF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srtf scheduler check failed");

// next-cycle implication
`define SRTF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srtf scheduler check failed");

`endif

>>> hdl/srtf_pkg.sv
// ----------------------------------------------------------------------------
// srtf_pkg
// shared types and field widths of the srtf scheduler
// ----------------------------------------------------------------------------
package srtf_pkg;

  localparam int TIME_W = 20;
  localparam int DATA_W = 16;
  localparam int SLOT_W = 4;
  localparam int CNT_W  = 5;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_CALC = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

endpackage

>>> hdl/srtf_preemptive_scheduler.sv
// ----------------------------------------------------------------------------
// srtf_preemptive_scheduler
// preemptive shortest-remaining-time-first scheduler over a slot table
// ----------------------------------------------------------------------------
// channel  dir  handshake          payload
// in       in   in_valid/in_stall  req_type, slot_index, arrival_time, burst_time
// out      out  out_valid/out_stall tick_time, ran_*, finished, *_time, all_done
// cfg      in   cfg_wr_en          cfg_wr_data (process_count)
//
// a load request skips the scan and raises its result from the emit state
// a tick request scans the configured slots, one slot table read per cycle
//   through the shared compare unit, then passes calc on a finish and emit;
//   the next request can be taken in the cycle the result is raised
// reset clears time, finish count, slot valid bits; process_count is 1
// in_stall is high during reset; a stalled result holds and the next request
//   is taken while it waits
// ----------------------------------------------------------------------------
module srtf_preemptive_scheduler #(
  parameter int MAX_SLOTS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_req_type,
  input  logic [srtf_pkg::SLOT_W-1:0] in_slot_index,
  input  logic [srtf_pkg::DATA_W-1:0] in_arrival_time,
  input  logic [srtf_pkg::DATA_W-1:0] in_burst_time,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [srtf_pkg::TIME_W-1:0] out_tick_time,
  output logic                        out_ran_valid,
  output logic [srtf_pkg::SLOT_W-1:0] out_ran_slot,
  output logic                        out_finished,
  output logic [srtf_pkg::TIME_W-1:0] out_completion_time,
  output logic [srtf_pkg::TIME_W-1:0] out_turnaround_time,
  output logic [srtf_pkg::TIME_W-1:0] out_waiting_time,
  output logic                        out_all_done,
  input  logic                        cfg_wr_en,
  input  logic [srtf_pkg::CNT_W-1:0]  cfg_wr_data
);
  import srtf_pkg::*;

  localparam int IW      = $clog2(MAX_SLOTS);
  localparam int CW      = (IW > CNT_W) ? IW : CNT_W;
  localparam int CNT_CAP = (MAX_SLOTS > 31) ? 31 : MAX_SLOTS;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  pcount_r;
  logic [CNT_W-1:0]  cnt;
  logic [TIME_W-1:0] cur_time_r;
  logic [CNT_W-1:0]  fin_cnt_r, fin_cnt_nxt;
  logic              is_tick_r;

  logic [DATA_W-1:0] arr_mem [MAX_SLOTS];
  logic [DATA_W-1:0] bur_mem [MAX_SLOTS];
  logic [DATA_W-1:0] rem_mem [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] vld_r;

  logic [CW-1:0]     scan_r;
  logic              pend_r;
  logic [IW-1:0]     pend_idx_r;
  logic [DATA_W-1:0] rd_arr_r, rd_bur_r, rd_rem_r;
  logic              rd_vld_r;
  logic              have_r;
  logic [IW-1:0]     best_r;
  logic [DATA_W-1:0] best_arr_r, best_bur_r, best_rem_r;
  logic [TIME_W-1:0] ct_r, tat_r;

  logic              accept, load_acc, load_ok, commit, scan_more, cand, take, fin;
  logic [IW-1:0]     rd_addr, load_addr;
  logic              rem_we;
  logic [IW-1:0]     rem_wa;
  logic [DATA_W-1:0] rem_wd;
  logic [TIME_W-1:0] wt;

  assign cnt       = (pcount_r > CNT_W'(CNT_CAP)) ? CNT_W'(CNT_CAP) : pcount_r;
  assign in_stall  = !rst_n || (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign load_acc  = accept && (in_req_type == REQ_LOAD);
  assign load_ok   = (32'(in_slot_index) < MAX_SLOTS);
  assign load_addr = IW'(in_slot_index);
  assign commit    = (state_r == ST_EMIT) && (!out_valid || !out_stall);
  assign scan_more = (scan_r < CW'(cnt));
  assign rd_addr   = scan_r[IW-1:0];

  assign cand = pend_r && rd_vld_r && (rd_rem_r != '0) &&
                ({{(TIME_W-DATA_W){1'b0}}, rd_arr_r} <= cur_time_r);
  assign take = cand && (!have_r || rd_rem_r <= best_rem_r);
  assign fin  = is_tick_r && have_r && (best_rem_r == DATA_W'(1));

  assign fin_cnt_nxt = (fin && fin_cnt_r != CNT_MAX) ? fin_cnt_r + 1'b1 : fin_cnt_r;

  assign wt = (tat_r >= {{(TIME_W-DATA_W){1'b0}}, best_bur_r}) ?
              tat_r - {{(TIME_W-DATA_W){1'b0}}, best_bur_r} : '0;

  // remaining-time write port: load or decrement
  always_comb begin
    rem_we = 1'b0;
    rem_wa = load_addr;
    rem_wd = in_burst_time;
    if (load_acc && load_ok) begin
      rem_we = 1'b1;
    end else if (commit && is_tick_r && have_r) begin
      rem_we = 1'b1;
      rem_wa = best_r;
      rem_wd = best_rem_r - 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_req_type == REQ_TICK) ? ST_SCAN : ST_EMIT;
        end
      end
      ST_SCAN: begin
        if (!scan_more && !pend_r) begin
          state_nxt = (have_r && best_rem_r == DATA_W'(1)) ? ST_CALC : ST_EMIT;
        end
      end
      ST_CALC: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // slot table
  always_ff @(posedge clk) begin
    if (load_acc && load_ok) begin
      arr_mem[load_addr] <= in_arrival_time;
      bur_mem[load_addr] <= in_burst_time;
    end
    if (rem_we) begin
      rem_mem[rem_wa] <= rem_wd;
    end
    rd_arr_r <= arr_mem[rd_addr];
    rd_bur_r <= bur_mem[rd_addr];
    rd_rem_r <= rem_mem[rd_addr];
    rd_vld_r <= vld_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      pcount_r   <= CNT_W'(1);
      cur_time_r <= '0;
      fin_cnt_r  <= '0;
      vld_r      <= '0;
      pend_r     <= 1'b0;
      have_r     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        pcount_r <= cfg_wr_data;
      end
      if (load_acc && load_ok) begin
        vld_r[load_addr] <= 1'b1;
      end
      if (accept) begin
        pend_r <= 1'b0;
        have_r <= 1'b0;
      end else if (state_r == ST_SCAN) begin
        pend_r <= scan_more;
        if (take) begin
          have_r <= 1'b1;
        end
      end
      if (commit) begin
        out_valid <= 1'b1;
        fin_cnt_r <= fin_cnt_nxt;
        if (is_tick_r && cur_time_r != TIME_MAX) begin
          cur_time_r <= cur_time_r + 1'b1;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      is_tick_r <= (in_req_type == REQ_TICK);
      scan_r    <= '0;
    end else if (state_r == ST_SCAN && scan_more) begin
      scan_r     <= scan_r + 1'b1;
      pend_idx_r <= rd_addr;
    end
    if (state_r == ST_SCAN && take) begin
      best_r     <= pend_idx_r;
      best_arr_r <= rd_arr_r;
      best_bur_r <= rd_bur_r;
      best_rem_r <= rd_rem_r;
    end
    if (state_r == ST_CALC) begin
      ct_r  <= (cur_time_r != TIME_MAX) ? cur_time_r + 1'b1 : TIME_MAX;
      tat_r <= ((cur_time_r != TIME_MAX) ? cur_time_r + 1'b1 : TIME_MAX) -
               {{(TIME_W-DATA_W){1'b0}}, best_arr_r};
    end
    if (commit) begin
      out_tick_time       <= cur_time_r;
      out_ran_valid       <= is_tick_r && have_r;
      out_ran_slot        <= (is_tick_r && have_r) ? SLOT_W'(best_r) : '0;
      out_finished        <= fin;
      out_completion_time <= fin ? ct_r : '0;
      out_turnaround_time <= fin ? tat_r : '0;
      out_waiting_time    <= fin ? wt : '0;
      out_all_done        <= (fin_cnt_nxt == cnt);
    end
  end

endmodule

>>> hdl/srtf_chk.sv
// ----------------------------------------------------------------------------
// srtf_chk
// port-level checks on the srtf scheduler input and result channels
// ----------------------------------------------------------------------------
`include "srtf_preemptive_scheduler_assert.svh"

module srtf_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [srtf_pkg::TIME_W-1:0] out_tick_time,
  input logic                        out_ran_valid,
  input logic [srtf_pkg::SLOT_W-1:0] out_ran_slot,
  input logic                        out_finished,
  input logic [srtf_pkg::TIME_W-1:0] out_completion_time,
  input logic [srtf_pkg::TIME_W-1:0] out_turnaround_time,
  input logic [srtf_pkg::TIME_W-1:0] out_waiting_time,
  input logic                        out_all_done
);
  import srtf_pkg::*;

  // accepted request blocks the input
  `SRTF_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  // stalled result stays
  `SRTF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `SRTF_ASSERT_NEXT(a_out_stable, out_valid && out_stall,
    $stable(out_tick_time) && $stable(out_ran_slot) && $stable(out_all_done))
  // idle or load requests carry no finish
  `SRTF_ASSERT_NOW(a_no_run_no_fin, out_valid && !out_ran_valid,
    !out_finished && out_ran_slot == '0 && out_completion_time == '0)
  // finish data consistent
  `SRTF_ASSERT_NOW(a_fin_times, out_valid && out_finished,
    out_ran_valid && out_completion_time != '0 &&
    out_turnaround_time >= out_waiting_time)

endmodule

bind srtf_preemptive_scheduler srtf_chk u_srtf_chk (.*);
